### rtl/buddy_page_allocator_top_macros.svh
// Assertion macros for the buddy page allocator.
// Used by modules that assert; they need clk and arst_n in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buddy allocator assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buddy allocator assertion failed");

`endif

### rtl/bpa_pkg.sv
// Shared types and constants of the buddy page allocator.
// No dependencies.
package bpa_pkg;

	localparam int XW = 17;
	localparam int OW = 4;
	localparam int CFG_W = 11;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] req_order;
		logic [9:0] frame_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] frame_out;
		logic [3:0] order_out;
	} out_item_t;

	typedef struct packed {
		logic [1:0]    flag;
		logic [OW-1:0] order;
	} meta_t;

	localparam logic [5:0] META_MASK_FLAG  = 6'b110000;
	localparam logic [5:0] META_MASK_ORDER = 6'b001111;
	localparam logic [5:0] META_MASK_ALL   = 6'b111111;

	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_FREE    = 2'd1;
	localparam logic [1:0] MODE_REBUILD = 2'd2;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
	localparam logic [1:0] STATUS_NO_BLOCK  = 2'd2;

	localparam logic [1:0] FLAG_USED = 2'd0;
	localparam logic [1:0] FLAG_HEAD = 2'd1;
	localparam logic [1:0] FLAG_TAIL = 2'd2;

	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_END   = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_ASCAN, ST_SPLIT, ST_FRD, ST_FCHK, ST_FBUD,
		ST_MW1, ST_MW2, ST_FFIN, ST_RB, ST_RM0, ST_RM1, ST_RM2, ST_AP0,
		ST_AP1, ST_RESP
	} bpa_state_t;

	typedef enum logic {RET_SPLIT, RET_MERGE} rm_ret_t;
	typedef enum logic [1:0] {APR_SPLIT, APR_FREE, APR_REBUILD} ap_ret_t;

endpackage

### rtl/bpa_ram.sv
// Synchronous RAM with bit write mask and registered read.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wmask,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		for (int k = 0; k < WIDTH; k++) begin
			if (we && wmask[k]) begin
				mem[waddr][k] <= wdata[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/buddy_page_allocator_top.sv
// Buddy page allocator: one transaction at a time through a sequencer over two RAMs.
// Depends on bpa_pkg, bpa_ram and buddy_page_allocator_top_macros.svh.
// After reset a clearing pass marks every frame used; no transaction is taken meanwhile.
// Allocate takes the head block of the lowest nonempty list at or above the requested order
// and splits it down, putting each upper half that lies inside the frame range on its list;
// an oversized request or a failed search is answered without a RAM access. Free merges the
// frame with its buddy, order by order, while the buddy heads a free block of that order,
// then puts the result on its list. Rebuild carves the configured window into blocks,
// stepping the order down where one would pass the window's end. The next transaction is
// taken in the cycle after the result is loaded. Each RAM has one read and one write port,
// and every list update goes through them one access at a time.
`include "buddy_page_allocator_top_macros.svh"

module buddy_page_allocator_top #(
	parameter int NUM_FRAMES = 1024,
	parameter int NUM_ORDERS = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bpa_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bpa_pkg::out_item_t        out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [bpa_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW  = $clog2(NUM_FRAMES);
	localparam int CW  = $clog2(NUM_FRAMES + 1);
	localparam int IW  = AW + 1;
	localparam int XW  = bpa_pkg::XW;
	localparam int OW  = bpa_pkg::OW;
	localparam int OIW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
	localparam int LW  = 2 * AW;
	localparam logic [XW-1:0] NF_X   = XW'(NUM_FRAMES);
	localparam logic [CW-1:0] NF_C   = CW'(NUM_FRAMES);
	localparam logic [IW-1:0] LAST_I = IW'(NUM_FRAMES - 1);
	localparam logic [IW-1:0] NF_I   = IW'(NUM_FRAMES);
	localparam logic [OW:0]   NO_X   = (OW + 1)'(NUM_ORDERS);
	localparam logic [OW-1:0] OMAX   = OW'(NUM_ORDERS - 1);
	localparam logic [LW-1:0] LINK_MASK_NXT = {{AW{1'b1}}, {AW{1'b0}}};
	localparam logic [LW-1:0] LINK_MASK_PRV = {{AW{1'b0}}, {AW{1'b1}}};
	localparam logic [LW-1:0] LINK_MASK_ALL = {LW{1'b1}};

	typedef struct packed {
		logic [AW-1:0] nxt;
		logic [AW-1:0] prv;
	} link_t;

	bpa_pkg::bpa_state_t state_q, state_d;
	logic [OW-1:0] req_q, req_d, o_q, o_d, p_q, p_d, rm_o_q, rm_o_d, ap_o_q, ap_o_d;
	logic [OW-1:0] ord_q, ord_d;
	logic [XW-1:0] f_q, f_d, b_q, b_d, left_q, left_d, rb_first_q, rb_first_d;
	logic [XW-1:0] rb_end_q, rb_end_d;
	logic [AW-1:0] rm_n_q, rm_n_d, rm_p_q, rm_p_d, ap_n_q, ap_n_d;
	bpa_pkg::rm_ret_t rm_ret_q, rm_ret_d;
	bpa_pkg::ap_ret_t ap_ret_q, ap_ret_d;
	logic [IW-1:0] idx_q, idx_d;
	bpa_pkg::out_item_t res_q, res_d, out_q;
	logic out_valid_q, res_load;
	logic [bpa_pkg::CFG_W-1:0] first_q, end_q;

	logic [AW-1:0] head_q [NUM_ORDERS];
	logic [AW-1:0] tail_q [NUM_ORDERS];
	logic [CW-1:0] cnt_q [NUM_ORDERS];
	logic head_we, tail_we, cnt_we, cnt_clr;
	logic [OIW-1:0] head_idx, tail_idx, cnt_idx;
	logic [AW-1:0] head_val, tail_val;
	logic [CW-1:0] cnt_val;

	logic meta_we, meta_re, link_we, link_re;
	logic [AW-1:0] meta_waddr, meta_raddr, link_waddr, link_raddr;
	logic [5:0] meta_wmask;
	bpa_pkg::meta_t meta_wdata, meta_rdata;
	logic [LW-1:0] link_wmask;
	link_t link_wdata, link_rdata;

	bpa_ram #(.WIDTH(6), .DEPTH(NUM_FRAMES)) u_meta_ram (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wmask(meta_wmask),
		.wdata(meta_wdata), .re(meta_re), .raddr(meta_raddr), .rdata(meta_rdata)
	);

	bpa_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wmask(link_wmask),
		.wdata(link_wdata), .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
	);

	assign in_ready  = (state_q == bpa_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			end_q   <= bpa_pkg::CFG_W'(1024);
		end else if (cfg_valid) begin
			if (cfg_index == bpa_pkg::CFG_FIRST) begin
				first_q <= cfg_data;
			end else begin
				end_q <= cfg_data;
			end
		end
	end

	always_comb begin
		logic [XW-1:0] fx, bx, span;
		logic [OW-1:0] pn, ofound;
		logic found;
		fx = '0;
		bx = '0;
		span = '0;
		pn = '0;
		ofound = '0;
		found = 1'b0;
		state_d = state_q;
		req_d = req_q;
		o_d = o_q;
		p_d = p_q;
		rm_o_d = rm_o_q;
		ap_o_d = ap_o_q;
		ord_d = ord_q;
		f_d = f_q;
		b_d = b_q;
		left_d = left_q;
		rb_first_d = rb_first_q;
		rb_end_d = rb_end_q;
		rm_n_d = rm_n_q;
		rm_p_d = rm_p_q;
		ap_n_d = ap_n_q;
		rm_ret_d = rm_ret_q;
		ap_ret_d = ap_ret_q;
		idx_d = idx_q;
		res_d = res_q;
		res_load = 1'b0;
		head_we = 1'b0;
		tail_we = 1'b0;
		cnt_we = 1'b0;
		cnt_clr = 1'b0;
		head_idx = '0;
		tail_idx = '0;
		cnt_idx = '0;
		head_val = '0;
		tail_val = '0;
		cnt_val = '0;
		meta_we = 1'b0;
		meta_re = 1'b0;
		meta_waddr = '0;
		meta_raddr = '0;
		meta_wmask = bpa_pkg::META_MASK_ALL;
		meta_wdata = '0;
		link_we = 1'b0;
		link_re = 1'b0;
		link_waddr = '0;
		link_raddr = '0;
		link_wmask = LINK_MASK_ALL;
		link_wdata = '0;
		case (state_q)
			bpa_pkg::ST_CLEAR: begin
				meta_we = 1'b1;
				meta_waddr = idx_q[AW-1:0];
				idx_d = idx_q + 1'b1;
				if (idx_q == LAST_I) begin
					state_d = bpa_pkg::ST_IDLE;
				end
			end
			bpa_pkg::ST_IDLE: begin
				if (in_valid) begin
					req_d = in_data.req_order;
					f_d = XW'(in_data.frame_in);
					case (in_data.mode)
						bpa_pkg::MODE_ALLOC: begin
							if ({1'b0, in_data.req_order} >= NO_X) begin
								res_d = '{bpa_pkg::STATUS_TOO_LARGE, 10'd0, 4'd0};
								state_d = bpa_pkg::ST_RESP;
							end else begin
								state_d = bpa_pkg::ST_ASCAN;
							end
						end
						bpa_pkg::MODE_FREE: begin
							if (XW'(in_data.frame_in) >= NF_X) begin
								res_d = '{bpa_pkg::STATUS_DONE, in_data.frame_in, 4'd0};
								state_d = bpa_pkg::ST_RESP;
							end else begin
								meta_re = 1'b1;
								meta_raddr = AW'(in_data.frame_in);
								state_d = bpa_pkg::ST_FRD;
							end
						end
						bpa_pkg::MODE_REBUILD: begin
							rb_first_d = (XW'(first_q) > NF_X) ? NF_X : XW'(first_q);
							rb_end_d = (XW'(end_q) > NF_X) ? NF_X : XW'(end_q);
							cnt_clr = 1'b1;
							idx_d = '0;
							ord_d = OMAX;
							left_d = '0;
							state_d = bpa_pkg::ST_RB;
						end
						default: begin
							res_d = '{bpa_pkg::STATUS_DONE, 10'd0, 4'd0};
							state_d = bpa_pkg::ST_RESP;
						end
					endcase
				end
			end
			bpa_pkg::ST_ASCAN: begin
				for (int k = 0; k < NUM_ORDERS; k++) begin
					if (!found && OW'(k) >= req_q && cnt_q[k] != '0) begin
						found = 1'b1;
						ofound = OW'(k);
					end
				end
				if (!found) begin
					res_d = '{bpa_pkg::STATUS_NO_BLOCK, 10'd0, 4'd0};
					state_d = bpa_pkg::ST_RESP;
				end else begin
					f_d = XW'(head_q[ofound[OIW-1:0]]);
					p_d = ofound;
					rm_o_d = ofound;
					rm_n_d = head_q[ofound[OIW-1:0]];
					rm_ret_d = bpa_pkg::RET_SPLIT;
					state_d = bpa_pkg::ST_RM0;
				end
			end
			bpa_pkg::ST_SPLIT: begin
				if (p_q > req_q) begin
					pn = p_q - 1'b1;
					bx = f_q + (XW'(1) << pn);
					p_d = pn;
					if (bx < NF_X) begin
						meta_we = 1'b1;
						meta_waddr = bx[AW-1:0];
						meta_wdata = '{bpa_pkg::FLAG_HEAD, pn};
						ap_o_d = pn;
						ap_n_d = bx[AW-1:0];
						ap_ret_d = bpa_pkg::APR_SPLIT;
						state_d = bpa_pkg::ST_AP0;
					end
				end else begin
					meta_we = 1'b1;
					meta_waddr = f_q[AW-1:0];
					meta_wdata = '{bpa_pkg::FLAG_USED, req_q};
					res_d = '{bpa_pkg::STATUS_DONE, f_q[9:0], req_q};
					state_d = bpa_pkg::ST_RESP;
				end
			end
			bpa_pkg::ST_FRD: begin
				o_d = ({1'b0, meta_rdata.order} >= NO_X) ? OMAX : meta_rdata.order;
				state_d = bpa_pkg::ST_FCHK;
			end
			bpa_pkg::ST_FCHK: begin
				bx = f_q ^ (XW'(1) << o_q);
				if ({1'b0, o_q} + 1'b1 < NO_X && bx < NF_X) begin
					meta_re = 1'b1;
					meta_raddr = bx[AW-1:0];
					b_d = bx;
					state_d = bpa_pkg::ST_FBUD;
				end else begin
					state_d = bpa_pkg::ST_FFIN;
				end
			end
			bpa_pkg::ST_FBUD: begin
				if (meta_rdata.flag == bpa_pkg::FLAG_HEAD && meta_rdata.order == o_q) begin
					rm_o_d = o_q;
					rm_n_d = b_q[AW-1:0];
					rm_ret_d = bpa_pkg::RET_MERGE;
					state_d = bpa_pkg::ST_RM0;
				end else begin
					state_d = bpa_pkg::ST_FFIN;
				end
			end
			bpa_pkg::ST_MW1: begin
				meta_we = 1'b1;
				meta_waddr = (b_q > f_q) ? b_q[AW-1:0] : f_q[AW-1:0];
				meta_wmask = bpa_pkg::META_MASK_FLAG;
				meta_wdata = '{bpa_pkg::FLAG_TAIL, 4'd0};
				state_d = bpa_pkg::ST_MW2;
			end
			bpa_pkg::ST_MW2: begin
				fx = (b_q > f_q) ? f_q : b_q;
				meta_we = 1'b1;
				meta_waddr = fx[AW-1:0];
				meta_wmask = bpa_pkg::META_MASK_ORDER;
				meta_wdata = '{bpa_pkg::FLAG_USED, o_q + 1'b1};
				f_d = fx;
				o_d = o_q + 1'b1;
				state_d = bpa_pkg::ST_FCHK;
			end
			bpa_pkg::ST_FFIN: begin
				meta_we = 1'b1;
				meta_waddr = f_q[AW-1:0];
				meta_wdata = '{bpa_pkg::FLAG_HEAD, o_q};
				ap_o_d = o_q;
				ap_n_d = f_q[AW-1:0];
				ap_ret_d = bpa_pkg::APR_FREE;
				state_d = bpa_pkg::ST_AP0;
			end
			bpa_pkg::ST_RB: begin
				fx = XW'(idx_q);
				span = fx + (XW'(1) << ord_q) - 1'b1;
				if (idx_q == NF_I) begin
					res_d = '{bpa_pkg::STATUS_DONE, 10'd0, 4'd0};
					state_d = bpa_pkg::ST_RESP;
				end else if (fx < rb_first_q || fx >= rb_end_q) begin
					meta_we = 1'b1;
					meta_waddr = idx_q[AW-1:0];
					meta_wdata = '{bpa_pkg::FLAG_USED, 4'd0};
					idx_d = idx_q + 1'b1;
				end else if (left_q == '0) begin
					if (ord_q != '0 && span >= rb_end_q) begin
						ord_d = ord_q - 1'b1;
					end else begin
						meta_we = 1'b1;
						meta_waddr = idx_q[AW-1:0];
						meta_wdata = '{bpa_pkg::FLAG_HEAD, ord_q};
						left_d = (XW'(1) << ord_q) - 1'b1;
						ap_o_d = ord_q;
						ap_n_d = idx_q[AW-1:0];
						ap_ret_d = bpa_pkg::APR_REBUILD;
						idx_d = idx_q + 1'b1;
						state_d = bpa_pkg::ST_AP0;
					end
				end else begin
					meta_we = 1'b1;
					meta_waddr = idx_q[AW-1:0];
					meta_wdata = '{bpa_pkg::FLAG_TAIL, 4'd0};
					left_d = left_q - 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end
			bpa_pkg::ST_RM0: begin
				if (cnt_q[rm_o_q[OIW-1:0]] == CW'(1)) begin
					cnt_we = 1'b1;
					cnt_idx = rm_o_q[OIW-1:0];
					cnt_val = '0;
				end
				if (cnt_q[rm_o_q[OIW-1:0]] > CW'(1)) begin
					link_re = 1'b1;
					link_raddr = rm_n_q;
					state_d = bpa_pkg::ST_RM1;
				end else begin
					state_d = (rm_ret_q == bpa_pkg::RET_SPLIT) ? bpa_pkg::ST_SPLIT :
						bpa_pkg::ST_MW1;
				end
			end
			bpa_pkg::ST_RM1: begin
				rm_p_d = link_rdata.prv;
				rm_n_d = link_rdata.nxt;
				if (rm_n_q == head_q[rm_o_q[OIW-1:0]]) begin
					head_we = 1'b1;
					head_idx = rm_o_q[OIW-1:0];
					head_val = link_rdata.nxt;
				end else begin
					link_we = 1'b1;
					link_waddr = link_rdata.prv;
					link_wmask = LINK_MASK_NXT;
					link_wdata = '{link_rdata.nxt, {AW{1'b0}}};
				end
				b_d = b_q;
				ap_n_d = rm_n_q;
				state_d = bpa_pkg::ST_RM2;
			end
			bpa_pkg::ST_RM2: begin
				if (ap_n_q == tail_q[rm_o_q[OIW-1:0]]) begin
					tail_we = 1'b1;
					tail_idx = rm_o_q[OIW-1:0];
					tail_val = rm_p_q;
				end else begin
					link_we = 1'b1;
					link_waddr = rm_n_q;
					link_wmask = LINK_MASK_PRV;
					link_wdata = '{{AW{1'b0}}, rm_p_q};
				end
				cnt_we = 1'b1;
				cnt_idx = rm_o_q[OIW-1:0];
				cnt_val = cnt_q[rm_o_q[OIW-1:0]] - 1'b1;
				state_d = (rm_ret_q == bpa_pkg::RET_SPLIT) ? bpa_pkg::ST_SPLIT :
					bpa_pkg::ST_MW1;
			end
			bpa_pkg::ST_AP0: begin
				if (cnt_q[ap_o_q[OIW-1:0]] != '0) begin
					link_we = 1'b1;
					link_waddr = tail_q[ap_o_q[OIW-1:0]];
					link_wmask = LINK_MASK_NXT;
					link_wdata = '{ap_n_q, {AW{1'b0}}};
				end
				state_d = bpa_pkg::ST_AP1;
			end
			bpa_pkg::ST_AP1: begin
				link_we = 1'b1;
				link_waddr = ap_n_q;
				link_wdata = '{ap_n_q, (cnt_q[ap_o_q[OIW-1:0]] == '0) ? ap_n_q :
					tail_q[ap_o_q[OIW-1:0]]};
				if (cnt_q[ap_o_q[OIW-1:0]] == '0) begin
					head_we = 1'b1;
					head_idx = ap_o_q[OIW-1:0];
					head_val = ap_n_q;
				end
				tail_we = 1'b1;
				tail_idx = ap_o_q[OIW-1:0];
				tail_val = ap_n_q;
				if (cnt_q[ap_o_q[OIW-1:0]] < NF_C) begin
					cnt_we = 1'b1;
					cnt_idx = ap_o_q[OIW-1:0];
					cnt_val = cnt_q[ap_o_q[OIW-1:0]] + 1'b1;
				end
				case (ap_ret_q)
					bpa_pkg::APR_SPLIT: state_d = bpa_pkg::ST_SPLIT;
					bpa_pkg::APR_FREE: begin
						res_d = '{bpa_pkg::STATUS_DONE, f_q[9:0], o_q};
						state_d = bpa_pkg::ST_RESP;
					end
					default: state_d = bpa_pkg::ST_RB;
				endcase
			end
			bpa_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					res_load = 1'b1;
					state_d = bpa_pkg::ST_IDLE;
				end
			end
			default: state_d = bpa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::ST_CLEAR;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_ORDERS; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cnt_clr) begin
				for (int k = 0; k < NUM_ORDERS; k++) begin
					cnt_q[k] <= '0;
				end
			end else if (cnt_we) begin
				cnt_q[cnt_idx] <= cnt_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		o_q <= o_d;
		p_q <= p_d;
		rm_o_q <= rm_o_d;
		ap_o_q <= ap_o_d;
		ord_q <= ord_d;
		f_q <= f_d;
		b_q <= b_d;
		left_q <= left_d;
		rb_first_q <= rb_first_d;
		rb_end_q <= rb_end_d;
		rm_n_q <= rm_n_d;
		rm_p_q <= rm_p_d;
		ap_n_q <= ap_n_d;
		rm_ret_q <= rm_ret_d;
		ap_ret_q <= ap_ret_d;
		res_q <= res_d;
		if (res_load) begin
			out_q <= res_q;
		end
		if (head_we) begin
			head_q[head_idx] <= head_val;
		end
		if (tail_we) begin
			tail_q[tail_idx] <= tail_val;
		end
	end

	`BPA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_q != bpa_pkg::ST_IDLE)
	`BPA_ASSERT_IMP(a_meta_no_rw_clash, meta_we && meta_re, meta_waddr != meta_raddr)
	`BPA_ASSERT_IMP(a_link_no_rw_clash, link_we && link_re, link_waddr != link_raddr)
	`BPA_ASSERT_NEXT(a_resp_holds, state_q == bpa_pkg::ST_RESP && out_valid_q && !out_ready, state_q == bpa_pkg::ST_RESP)

endmodule
